### rtl/pls_pkg.sv
// Shared constants and types for the positional list store.
package pls_pkg;

  localparam int CAPACITY  = 64;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int LEN_W     = $clog2(CAPACITY + 1);
  localparam int POS_W     = $clog2(CAPACITY + 1);
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

endpackage

### rtl/pls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/positional_list_store.sv
// Positional list store: bounded ordered list with insert and delete at a position.
//
// The list lives in a RAM of CAPACITY words. One transaction is taken at a time;
// in_stall is high from acceptance until the result is loaded into the output
// register. A single index counter walks the RAM, each element moved by a read
// state and then a write state. An insert shifts elements up from the end, a
// delete shifts them down from the position; a rejected operation goes straight
// to the finish state, which holds while an earlier result waits on out_stall.
// The result register holds one pending result, so the next transaction can
// enter while the previous result waits.
module positional_list_store (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic [pls_pkg::POS_W-1:0]         in_position,
  input  logic signed [pls_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pls_pkg::STATUS_W-1:0]      out_status,
  output logic signed [pls_pkg::DATA_W-1:0] out_removed_value,
  output logic [pls_pkg::LEN_W-1:0]         out_length
);

  import pls_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD0,
    S_DEL_TAKE,
    S_DEL_RD,
    S_DEL_WR,
    S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [DATA_W-1:0]   val_r, val_nxt;
  logic [LEN_W-1:0]    idx_r, idx_nxt;
  logic [LEN_W-1:0]    count_r, count_nxt;
  logic [DATA_W-1:0]   removed_r, removed_nxt;
  status_t             status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [DATA_W-1:0]   out_removed_r, out_removed_nxt;
  logic [LEN_W-1:0]    out_length_r, out_length_nxt;

  logic [LEN_W-1:0]    idx_dec;
  logic [LEN_W-1:0]    idx_inc;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;

  assign idx_dec = idx_r - 1'b1;
  assign idx_inc = idx_r + 1'b1;

  pls_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    val_nxt         = val_r;
    idx_nxt         = idx_r;
    count_nxt       = count_r;
    removed_nxt     = removed_r;
    status_nxt      = status_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_length_nxt  = out_length_r;
    ram_we          = 1'b0;
    ram_waddr       = idx_r[ADDR_W-1:0];
    ram_wdata       = ram_rdata;
    ram_raddr       = idx_r[ADDR_W-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pos_nxt     = in_position;
          val_nxt     = in_value;
          removed_nxt = '0;
          status_nxt  = ST_OK;
          if (op_t'(in_operation) == OP_INSERT) begin
            if (in_position > count_r) begin
              status_nxt = ST_RANGE;
              state_nxt  = S_FIN;
            end else if (count_r == LEN_W'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_FIN;
            end else begin
              idx_nxt   = count_r;
              state_nxt = S_INS_RD;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_FIN;
            end else if (in_position >= count_r) begin
              status_nxt = ST_RANGE;
              state_nxt  = S_FIN;
            end else begin
              state_nxt = S_DEL_RD0;
            end
          end
        end
      end
      S_INS_RD: begin
        if (idx_r == pos_r) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r[ADDR_W-1:0];
          ram_wdata = val_r;
          count_nxt = count_r + 1'b1;
          state_nxt = S_FIN;
        end else begin
          ram_raddr = idx_dec[ADDR_W-1:0];
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        idx_nxt   = idx_dec;
        state_nxt = S_INS_RD;
      end
      S_DEL_RD0: begin
        ram_raddr = pos_r[ADDR_W-1:0];
        idx_nxt   = pos_r;
        state_nxt = S_DEL_TAKE;
      end
      S_DEL_TAKE: begin
        removed_nxt = ram_rdata;
        state_nxt   = S_DEL_RD;
      end
      S_DEL_RD: begin
        if (idx_inc >= count_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_FIN;
        end else begin
          ram_raddr = idx_inc[ADDR_W-1:0];
          state_nxt = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        ram_we    = 1'b1;
        idx_nxt   = idx_inc;
        state_nxt = S_DEL_RD;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_removed_nxt = removed_r;
          out_length_nxt  = count_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r         <= pos_nxt;
    val_r         <= val_nxt;
    idx_r         <= idx_nxt;
    removed_r     <= removed_nxt;
    status_r      <= status_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_length_r  <= out_length_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_length        = out_length_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LEN_W'(CAPACITY))
    else $error("element count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("transaction accepted without going busy");

  a_removed_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_removed_value == '0))
    else $error("failed operation reports a removed value");

  a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ({1'b0, ram_waddr} <= count_r))
    else $error("RAM write beyond list length");

endmodule

### tb/sv/tb_positional_list_store.sv
// Testbench for the positional list store: predicted insert/delete results under random flow control.
module tb_positional_list_store;
  timeunit 1ns;
  timeprecision 1ps;
  import pls_pkg::*;

  localparam int TOTAL_ITEMS  = 1900;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;
  localparam int MAX_REPORTS  = 10;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] removed;
    logic [LEN_W-1:0]         length;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_operation = 1'b0;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic signed [DATA_W-1:0] out_removed_value;
  logic [LEN_W-1:0]         out_length;

  // predictor state
  logic signed [DATA_W-1:0] list_mem [CAPACITY];
  logic [LEN_W-1:0]         list_len = '0;
  list_result_t             result_q [$];

  // sender state
  logic [LEN_W-1:0] plan_len = '0;
  int               burst_left = 0;
  bit               no_gaps = 1'b0;
  bit               hold_req = 1'b0;
  int               items_sent = 0;

  // statistics
  int fail_count = 0;
  int idle_cycles = 0;
  int n_insert = 0;
  int n_delete = 0;
  int peak_len = 0;
  int status_hits [4] = '{0, 0, 0, 0};

  positional_list_store u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_length        (out_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic predict_list_op(input logic op, input logic [POS_W-1:0] pos,
                                 input logic signed [DATA_W-1:0] val);
    list_result_t r;
    int i;
    r.removed = '0;
    if (op == OP_INSERT) begin
      n_insert++;
      if (pos > list_len) begin
        r.status = ST_RANGE;
      end else if (list_len >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        for (i = int'(list_len); i > int'(pos); i--) list_mem[i] = list_mem[i-1];
        list_mem[pos] = val;
        list_len++;
        r.status = ST_OK;
      end
    end else begin
      n_delete++;
      if (list_len == 0) begin
        r.status = ST_EMPTY;
      end else if (pos >= list_len) begin
        r.status = ST_RANGE;
      end else begin
        r.removed = list_mem[pos];
        for (i = int'(pos); i + 1 < int'(list_len); i++) list_mem[i] = list_mem[i+1];
        list_len--;
        r.status = ST_OK;
      end
    end
    r.length = list_len;
    if (int'(list_len) > peak_len) peak_len = list_len;
    status_hits[r.status]++;
    result_q.push_back(r);
  endtask

  task automatic check_list_result();
    list_result_t want;
    if (result_q.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: result with no transaction pending: status %0d removed %0d length %0d",
                 $realtime, out_status, out_removed_value, out_length);
    end else begin
      want = result_q.pop_front();
      if (out_status != want.status || out_removed_value != want.removed ||
          out_length != want.length) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: mismatch: status %0d/%0d removed %0d/%0d length %0d/%0d (exp/got)",
                   $realtime, want.status, out_status, want.removed, out_removed_value,
                   want.length, out_length);
      end
    end
  endtask

  // monitor: check outputs, predict accepted inputs, watch for a hang
  always @(posedge clk) begin : monitor
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        check_list_result();
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        predict_list_op(in_operation, in_position, in_value);
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: watchdog: no transaction for %0d cycles, %0d results outstanding",
                   $realtime, IDLE_LIMIT, result_q.size());
          $display("** positional_list_store: FAILED **");
          $finish;
        end
      end
    end
  end

  // receiver stall pattern, plus long hold-off on request
  initial begin : receiver
    int run_left;
    int mode;
    run_left = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          mode = $urandom_range(0, 2);
          run_left = $urandom_range(5, 60);
        end
        run_left--;
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 99) < 30);
          end
          default: begin
            out_stall <= ($urandom_range(0, 99) < 75);
          end
        endcase
      end
    end
  end

  task automatic send_list_op(input op_t op, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_value     <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (op == OP_INSERT) begin
      if (pos <= plan_len && plan_len < CAPACITY) plan_len++;
    end else begin
      if (plan_len != 0 && pos < plan_len) plan_len--;
    end
  endtask

  task automatic test_directed_edges();
    send_list_op(OP_DELETE, 0, 32'sd0);              // delete on empty
    send_list_op(OP_DELETE, POS_MAX, -32'sd1);       // delete on empty, top position
    send_list_op(OP_INSERT, 1, 32'sd5);              // insert past end
    send_list_op(OP_INSERT, POS_MAX, 32'sd6);
    send_list_op(OP_INSERT, 0, 32'sh7FFF_FFFF);
    send_list_op(OP_INSERT, 1, 32'sh8000_0000);      // append
    send_list_op(OP_INSERT, 1, 32'sd0);              // middle
    send_list_op(OP_INSERT, 0, -32'sd1);             // front
    send_list_op(OP_INSERT, 4, 32'sh5555_5555);      // append
    send_list_op(OP_INSERT, 2, 32'shAAAA_AAAA);
    send_list_op(OP_INSERT, 7, 32'sd1);              // past end
    send_list_op(OP_DELETE, 6, 32'sd0);              // delete past end
    send_list_op(OP_DELETE, POS_MAX, 32'sd0);
    send_list_op(OP_DELETE, 5, 32'sd0);              // back
    send_list_op(OP_DELETE, 0, 32'sd0);              // front
    send_list_op(OP_DELETE, 1, -32'sd1);             // middle
    send_list_op(OP_DELETE, 1, 32'sd0);
    send_list_op(OP_DELETE, 0, 32'sd0);
    send_list_op(OP_DELETE, 0, 32'sd0);
    send_list_op(OP_DELETE, 0, 32'sd0);              // empty again
  endtask

  task automatic test_fill_and_drain();
    int rep;
    for (rep = 0; rep < 2; rep++) begin
      while (plan_len < CAPACITY) send_list_op(OP_INSERT, $urandom_range(0, plan_len), $urandom);
      send_list_op(OP_INSERT, CAPACITY, $urandom);       // full
      send_list_op(OP_INSERT, 0, $urandom);              // full
      send_list_op(OP_INSERT, CAPACITY + 1, $urandom);   // bad position wins over full
      send_list_op(OP_INSERT, POS_MAX, $urandom);
      send_list_op(OP_DELETE, CAPACITY, $urandom);
      send_list_op(OP_DELETE, POS_MAX, $urandom);
      while (plan_len > 0) send_list_op(OP_DELETE, $urandom_range(0, plan_len - 1), $urandom);
      send_list_op(OP_DELETE, $urandom_range(0, POS_MAX), $urandom);
    end
  endtask

  task automatic test_output_backpressure();
    int k;
    hold_req = 1'b1;
    no_gaps = 1'b1;
    burst_left = 0;
    for (k = 0; k < 10; k++) send_list_op(OP_INSERT, $urandom_range(0, plan_len), $urandom);
    no_gaps = 1'b0;
  endtask

  task automatic test_random_mix();
    int bias;
    int k;
    op_t op;
    logic [POS_W-1:0] pos;
    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 2))
        0: bias = 25;
        1: bias = 50;
        default: bias = 75;
      endcase
      for (k = 0; k < 60; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          op = op_t'($urandom_range(0, 1));
          pos = $urandom_range(0, POS_MAX);
        end else if ($urandom_range(0, 99) < bias) begin
          op = OP_INSERT;
          pos = $urandom_range(0, plan_len);
        end else begin
          op = OP_DELETE;
          pos = (plan_len == 0) ? '0 : $urandom_range(0, plan_len - 1);
        end
        send_list_op(op, pos, $urandom);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_fill_and_drain();
    test_output_backpressure();
    test_random_mix();

    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d transactions: %0d inserts, %0d deletes, list peaked at %0d of %0d",
             items_sent, n_insert, n_delete, peak_len, CAPACITY);
    $display("statuses seen: ok %0d, bad position %0d, empty %0d, full %0d; %0d failures",
             status_hits[ST_OK], status_hits[ST_RANGE], status_hits[ST_EMPTY],
             status_hits[ST_FULL], fail_count);
    if (fail_count == 0) begin
      $display("** positional_list_store: PASSED **");
    end else begin
      $display("** positional_list_store: FAILED **");
    end
    $finish;
  end

endmodule
